>>> rtl/irr_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// irr_pkg
// Shared types, constants and helpers of the interrupt router register block.
// ============================================================================
package irr_pkg;

    // Design size
    localparam int LINE_COUNT = 32;
    localparam int CORE_COUNT = 4;
    localparam int LINE_W     = $clog2(LINE_COUNT);
    localparam int CORE_W     = 2;
    localparam int CFG_W      = 3;

    // Stream payload widths (bytes padded)
    localparam int S_TDATA_W  = 88;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 72;
    localparam int M_TUSER_W  = 1;

    // Register window byte offsets
    localparam logic [8:0] OFS_ROUTE_END = 9'h020;
    localparam logic [8:0] OFS_PENDING   = 9'h020;
    localparam logic [8:0] OFS_ENABLE    = 9'h024;
    localparam logic [8:0] OFS_EN_SET    = 9'h028;
    localparam logic [8:0] OFS_EN_CLR    = 9'h02c;
    localparam logic [8:0] OFS_EDGE      = 9'h038;
    localparam logic [8:0] OFS_CORE_BASE = 9'h040;
    localparam logic [8:0] OFS_CORE_END  = 9'h060;
    localparam logic [8:0] WINDOW_END    = 9'h100;

    // Item action codes
    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_LINE  = 2'd2
    } action_t;

    // Result kinds
    typedef enum logic {
        KIND_READ = 1'b0,
        KIND_PIN  = 1'b1
    } kind_t;

    // Pin level codes
    localparam logic PIN_LOW  = 1'b0;
    localparam logic PIN_HIGH = 1'b1;

    // First core pin driven by the router
    localparam logic [2:0] PIN_BASE = 3'd2;

    // One input item
    typedef struct packed {
        logic [1:0]        action;
        logic [7:0]        address;
        logic [3:0]        access_bytes;
        logic [63:0]       write_data;
        logic [LINE_W-1:0] irq_number;
        logic              irq_level;
    } item_t;

    // One result item plus a flag saying whether the item produced one
    typedef struct packed {
        logic              has_result;
        logic              result_kind;
        logic [63:0]       read_data;
        logic [CORE_W-1:0] core_index;
        logic [2:0]        core_pin;
        logic              pin_level;
    } result_t;

    // Bus access sizes of 1, 2, 4 or 8 bytes are legal
    function automatic logic valid_size(input logic [3:0] n);
        return (n == 4'd1) || (n == 4'd2) || (n == 4'd4) || (n == 4'd8);
    endfunction

    // Index of the lowest set bit of a nibble (zero when the nibble is zero)
    function automatic logic [1:0] lowest_bit(input logic [3:0] v);
        logic [1:0] idx;
        idx = 2'd0;
        if (v[0])      idx = 2'd0;
        else if (v[1]) idx = 2'd1;
        else if (v[2]) idx = 2'd2;
        else if (v[3]) idx = 2'd3;
        return idx;
    endfunction

endpackage

>>> rtl/interrupt_router_registers_core.sv
`timescale 1ns / 1ps
// ============================================================================
// interrupt_router_registers_core
// Interrupt router for 32 lines and 4 cores with a 256-byte register window.
// ============================================================================
// An item is either a bus read, a bus write or an interrupt line level change
// (selected by s_axis_tuser). Each item is registered on entry, decoded
// against the register file once the output register is free or draining,
// and its result, if any, lands in an output register: one item per clock
// unless m_axis_tready holds the flow. Reads always return one item; writes
// return nothing; a line event returns a core pin change unless the line is
// disabled, its pin nibble is zero, or it is a fall while the core still has
// other lines pending. The online core count must be written through the cfg
// port while the block is idle (not enforced by the block); it resets to one.
module interrupt_router_registers_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input items
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // address[7:0], access_bytes[11:8], write_data[75:12], irq_number[80:76],
    // irq_level[81], zero pad[87:82]
    input  logic [irr_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // action[1:0]
    input  logic [irr_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    // Result items
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // read_data[63:0], core_index[65:64], core_pin[68:66], pin_level[69],
    // zero pad[71:70]
    output logic [irr_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // result_kind[0]
    output logic [irr_pkg::M_TUSER_W-1:0]   m_axis_tuser,
    // Online core count
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [irr_pkg::CFG_W-1:0]       cfg_data
);

    logic                        in_valid_reg;
    irr_pkg::item_t              in_item_reg;
    logic                        out_valid_reg;
    irr_pkg::result_t            out_res_reg;
    logic [irr_pkg::CFG_W-1:0]   online_reg;
    irr_pkg::result_t            res;
    logic                        proc_go;

    // Process the held item when the output slot is free or draining
    assign proc_go       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proc_go;
    assign cfg_ready     = 1'b1;

    irr_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_en     (proc_go),
        .item        (in_item_reg),
        .online_cpus (online_reg),
        .result      (res)
    );

    // Input and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            online_reg    <= irr_pkg::CFG_W'(1);
        end else begin
            if (cfg_valid && cfg_ready) begin
                online_reg <= cfg_data;
            end
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (proc_go) begin
                out_valid_reg <= res.has_result;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (s_axis_tvalid && s_axis_tready) begin
            in_item_reg.action       <= s_axis_tuser[1:0];
            in_item_reg.address      <= s_axis_tdata[7:0];
            in_item_reg.access_bytes <= s_axis_tdata[11:8];
            in_item_reg.write_data   <= s_axis_tdata[75:12];
            in_item_reg.irq_number   <= s_axis_tdata[80:76];
            in_item_reg.irq_level    <= s_axis_tdata[81];
        end
        if (proc_go && res.has_result) begin
            out_res_reg <= res;
        end
    end

    // Output packing
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_res_reg.pin_level, out_res_reg.core_pin,
                            out_res_reg.core_index, out_res_reg.read_data};
    assign m_axis_tuser  = out_res_reg.result_kind;

endmodule

>>> rtl/irr_regs.sv
`timescale 1ns / 1ps
// ============================================================================
// irr_regs
// Register file of the router: route bytes, enable/edge/pending words and
// per-core pending words. Decodes one item per enabled cycle: bus reads and
// writes on the byte window, and line events that update pending state.
// ============================================================================
module irr_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           item_en,      // item processed this cycle
    input  irr_pkg::item_t                 item,
    input  logic [irr_pkg::CFG_W-1:0]      online_cpus,
    output irr_pkg::result_t               result
);

    logic [7:0]  route_reg     [irr_pkg::LINE_COUNT];
    logic [7:0]  route_next    [irr_pkg::LINE_COUNT];
    logic [31:0] enable_reg, enable_next;
    logic [31:0] edge_reg, edge_next;
    logic [31:0] pending_reg, pending_next;
    logic [31:0] core_pend_reg  [irr_pkg::CORE_COUNT];
    logic [31:0] core_pend_next [irr_pkg::CORE_COUNT];

    logic                          is_read, is_write, is_line, size_ok;
    logic [63:0]                   rd_data;

    // Line event decode
    logic [7:0]                    line_route;
    logic [3:0]                    pin_nib, core_nib;
    logic [1:0]                    core_raw;
    logic [irr_pkg::CORE_W-1:0]    core_sel;
    logic [2:0]                    pin_sel;
    logic [31:0]                   line_bit;
    logic                          line_hit;
    logic [31:0]                   core_pend_cleared;

    assign is_read  = (item.action == irr_pkg::ACT_READ);
    assign is_write = (item.action == irr_pkg::ACT_WRITE);
    assign is_line  = (item.action == irr_pkg::ACT_LINE);
    assign size_ok  = irr_pkg::valid_size(item.access_bytes);

    // Bus read: eight byte lanes, each decoding its own window offset
    always_comb begin
        logic [8:0] a;
        logic [7:0] b;
        rd_data = '0;
        for (int k = 0; k < 8; k++) begin
            a = {1'b0, item.address} + 9'(k);
            b = '0;
            if (a < irr_pkg::OFS_ROUTE_END) begin
                b = route_reg[a[4:0]];
            end else if (a >= irr_pkg::OFS_PENDING && a < irr_pkg::OFS_PENDING + 9'd4) begin
                b = pending_reg[a[1:0]*8 +: 8];
            end else if (a >= irr_pkg::OFS_ENABLE && a < irr_pkg::OFS_ENABLE + 9'd4) begin
                b = enable_reg[a[1:0]*8 +: 8];
            end else if (a >= irr_pkg::OFS_EDGE && a < irr_pkg::OFS_EDGE + 9'd4) begin
                b = edge_reg[a[1:0]*8 +: 8];
            end else if (a >= irr_pkg::OFS_CORE_BASE && a < irr_pkg::OFS_CORE_END) begin
                // 8-byte stride per core, upper half reads zero
                if (!a[2]) begin
                    b = core_pend_reg[a[4:3]][a[1:0]*8 +: 8];
                end
            end
            if (k < int'(item.access_bytes) && a < irr_pkg::WINDOW_END && size_ok) begin
                rd_data[k*8 +: 8] = b;
            end
        end
    end

    // Line event: pick pin and core from the route byte
    assign line_route = route_reg[item.irq_number];
    assign pin_nib    = line_route[7:4];
    assign core_nib   = line_route[3:0];
    assign core_raw   = irr_pkg::lowest_bit(core_nib);
    assign pin_sel    = irr_pkg::PIN_BASE + {1'b0, irr_pkg::lowest_bit(pin_nib)};
    assign line_bit   = 32'd1 << item.irq_number;

    // Cores beyond the online count fall back to core zero
    always_comb begin
        core_sel = core_raw;
        if ({1'b0, core_raw} >= online_cpus ||
            32'(core_raw) >= 32'(irr_pkg::CORE_COUNT)) begin
            core_sel = '0;
        end
    end

    assign line_hit = is_line && ((enable_reg & line_bit) != '0) && (pin_nib != 4'd0);
    assign core_pend_cleared = core_pend_reg[core_sel] & ~line_bit;

    // Next state
    always_comb begin
        logic [8:0] off;
        logic [31:0] set_d, clr_d;
        logic        do_set, do_clr;
        route_next   = route_reg;
        enable_next  = enable_reg;
        edge_next    = edge_reg;
        pending_next = pending_reg;
        core_pend_next = core_pend_reg;
        off    = '0;
        set_d  = '0;
        clr_d  = '0;
        do_set = 1'b0;
        do_clr = 1'b0;

        if (is_write && size_ok) begin
            // Route bytes: stored while the offset stays inside the route area
            for (int j = 0; j < irr_pkg::LINE_COUNT; j++) begin
                off = 9'(j) - {1'b0, item.address};
                if (9'(j) >= {1'b0, item.address} && off < {5'b0, item.access_bytes}) begin
                    route_next[j] = item.write_data[off[2:0]*8 +: 8];
                end
            end
            // Enable set port, with the clear port in the upper half of an 8-byte write
            if ({1'b0, item.address} == irr_pkg::OFS_EN_SET && item.access_bytes >= 4'd4) begin
                do_set = 1'b1;
                set_d  = item.write_data[31:0];
                if (item.access_bytes == 4'd8) begin
                    do_clr = 1'b1;
                    clr_d  = item.write_data[63:32];
                end
            end
            if ({1'b0, item.address} == irr_pkg::OFS_EN_CLR && item.access_bytes >= 4'd4) begin
                do_clr = 1'b1;
                clr_d  = item.write_data[31:0];
            end
            if ({1'b0, item.address} == irr_pkg::OFS_EDGE && item.access_bytes >= 4'd4) begin
                edge_next = item.write_data[31:0];
            end
            if (do_set) begin
                enable_next = enable_next | set_d;
            end
            // Clearing an enable also drops pending for edge-triggered lines
            if (do_clr) begin
                enable_next  = enable_next & ~clr_d;
                pending_next = pending_reg & ~(clr_d & edge_reg);
            end
        end

        if (line_hit) begin
            if (item.irq_level) begin
                pending_next            = pending_reg | line_bit;
                core_pend_next[core_sel] = core_pend_reg[core_sel] | line_bit;
            end else begin
                pending_next            = pending_reg & ~line_bit;
                core_pend_next[core_sel] = core_pend_cleared;
            end
        end
    end

    // Result of the item
    always_comb begin
        result = '0;
        if (is_read) begin
            result.has_result  = 1'b1;
            result.result_kind = irr_pkg::KIND_READ;
            result.read_data   = rd_data;
        end else if (line_hit && (item.irq_level || core_pend_cleared == '0)) begin
            result.has_result  = 1'b1;
            result.result_kind = irr_pkg::KIND_PIN;
            result.core_index  = core_sel;
            result.core_pin    = pin_sel;
            result.pin_level   = item.irq_level ? irr_pkg::PIN_HIGH : irr_pkg::PIN_LOW;
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < irr_pkg::LINE_COUNT; j++) begin
                route_reg[j] <= '0;
            end
            for (int c = 0; c < irr_pkg::CORE_COUNT; c++) begin
                core_pend_reg[c] <= '0;
            end
            enable_reg  <= '0;
            edge_reg    <= '0;
            pending_reg <= '0;
        end else if (item_en) begin
            route_reg     <= route_next;
            core_pend_reg <= core_pend_next;
            enable_reg    <= enable_next;
            edge_reg      <= edge_next;
            pending_reg   <= pending_next;
        end
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the interrupt router register block.
// ============================================================================
// Items go in over the s_axis stream: bus reads, bus writes and line level
// changes. A model kept in the bench (route bytes, enable/edge/pending words,
// per-core pending words, online core count) predicts each read value and
// each core pin change. The results are checked in order against m_axis.
// Both stream sides idle at random. The online core count is changed between
// traffic phases, while the block is quiet.
module tb;
    import irr_pkg::*;

    localparam int IDLE_CYCLES = 8;   // pipeline is two deep; wait past it

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data = '0;

    // Router state as the bench sees it
    logic [7:0]  route_q [32];
    logic [31:0] enable_q;
    logic [31:0] edge_q;
    logic [31:0] pending_q;
    logic [31:0] core_pend_q [4];
    int unsigned online_q;

    // Read values and pin changes still to come out
    result_t     read_pin_q [$];
    result_t     head_r;
    int          mismatch_count = 0;
    bit          steady_flow = 1'b0;
    int          rx_hold = 0;

    interrupt_router_registers_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Router prediction
    // ------------------------------------------------------------------
    function automatic void clear_router();
        for (int i = 0; i < 32; i++) route_q[i] = 8'h00;
        for (int c = 0; c < 4; c++) core_pend_q[c] = 32'h0;
        enable_q  = 32'h0;
        edge_q    = 32'h0;
        pending_q = 32'h0;
        online_q  = 1;
    endfunction

    function automatic int unsigned first_one(input logic [3:0] v);
        for (int i = 0; i < 4; i++)
            if (v[i]) return i;
        return 0;
    endfunction

    function automatic bit size_ok(input int unsigned n);
        return n == 1 || n == 2 || n == 4 || n == 8;
    endfunction

    function automatic logic [7:0] window_byte(input int unsigned off);
        int unsigned sh;
        int unsigned rel;
        sh = (off & 3) * 8;
        if (off < 32) return route_q[off];
        if (off >= OFS_PENDING && off < OFS_PENDING + 4) return 8'(pending_q >> sh);
        if (off >= OFS_ENABLE && off < OFS_ENABLE + 4) return 8'(enable_q >> sh);
        if (off >= OFS_EDGE && off < OFS_EDGE + 4) return 8'(edge_q >> sh);
        if (off >= OFS_CORE_BASE && off < OFS_CORE_END) begin
            rel = off - OFS_CORE_BASE;
            if ((rel & 7) < 4) return 8'(core_pend_q[(rel >> 3) & 3] >> sh);
        end
        return 8'h00;
    endfunction

    function automatic logic [63:0] predict_read(input int unsigned addr,
                                                 input int unsigned n);
        logic [63:0] v;
        v = '0;
        if (!size_ok(n)) return v;
        for (int k = 0; k < n; k++)
            if (addr + k <= 255) v |= 64'(window_byte(addr + k)) << (8 * k);
        return v;
    endfunction

    function automatic void apply_write(input int unsigned addr, input int unsigned size,
                                        input logic [63:0] data);
        int unsigned off;
        int unsigned n;
        logic [63:0] d;
        off = addr;
        n   = size;
        d   = data;
        if (!size_ok(n)) return;
        // route bytes up to the end of the route block
        while (n > 0 && off < 32) begin
            route_q[off] = d[7:0];
            n--;
            off++;
            d = d >> 8;
        end
        if (off == OFS_EN_SET && n >= 4) begin
            enable_q |= d[31:0];
            off += 4;
            n   -= 4;
            d = d >> 32;
        end
        // clearing an enable also drops pending for edge lines
        if (off == OFS_EN_CLR && n >= 4) begin
            enable_q  &= ~d[31:0];
            pending_q &= ~(d[31:0] & edge_q);
            off += 4;
            n   -= 4;
            d = d >> 32;
        end
        if (off == OFS_EDGE && n >= 4) edge_q = d[31:0];
    endfunction

    function automatic bit predict_line(input logic [4:0] line, input logic lvl,
                                        output result_t r);
        logic [31:0] mask;
        logic [7:0]  rt;
        int unsigned pin;
        int unsigned core;
        r    = '0;
        mask = 32'h1 << line;
        if ((enable_q & mask) == 32'h0) return 1'b0;
        rt = route_q[line];
        if (rt[7:4] == 4'h0) return 1'b0;
        pin  = PIN_BASE + first_one(rt[7:4]);
        core = first_one(rt[3:0]);
        if (core >= online_q || core >= CORE_COUNT) core = 0;
        r.result_kind = KIND_PIN;
        r.core_index  = core[1:0];
        r.core_pin    = pin[2:0];
        if (lvl) begin
            pending_q         |= mask;
            core_pend_q[core] |= mask;
            r.pin_level = PIN_HIGH;
            return 1'b1;
        end
        pending_q         &= ~mask;
        core_pend_q[core] &= ~mask;
        if (core_pend_q[core] != 32'h0) return 1'b0;
        r.pin_level = PIN_LOW;
        return 1'b1;
    endfunction

    function automatic bit route_item(input item_t it, output result_t r);
        r = '0;
        case (it.action)
            ACT_READ: begin
                r.result_kind = KIND_READ;
                r.read_data   = predict_read(it.address, it.access_bytes);
                return 1'b1;
            end
            ACT_WRITE: begin
                apply_write(it.address, it.access_bytes, it.write_data);
                return 1'b0;
            end
            ACT_LINE: return predict_line(it.irq_number, it.irq_level, r);
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------
    function automatic item_t noise_item();
        item_t it;
        it.action       = ACT_READ;
        it.address      = 8'($urandom);
        it.access_bytes = 4'($urandom_range(1, 8));
        it.write_data   = {$urandom, $urandom};
        it.irq_number   = 5'($urandom);
        it.irq_level    = 1'($urandom);
        return it;
    endfunction

    function automatic item_t rd(input int unsigned addr, input int unsigned n);
        item_t it;
        it = noise_item();
        it.action       = ACT_READ;
        it.address      = 8'(addr);
        it.access_bytes = 4'(n);
        return it;
    endfunction

    function automatic item_t wr(input int unsigned addr, input int unsigned n,
                                 input logic [63:0] data);
        item_t it;
        it = noise_item();
        it.action       = ACT_WRITE;
        it.address      = 8'(addr);
        it.access_bytes = 4'(n);
        it.write_data   = data;
        return it;
    endfunction

    function automatic item_t ln(input int unsigned line, input bit lvl);
        item_t it;
        it = noise_item();
        it.action     = ACT_LINE;
        it.irq_number = 5'(line);
        it.irq_level  = lvl;
        return it;
    endfunction

    function automatic int unsigned legal_size();
        case ($urandom_range(3))
            0: return 1;
            1: return 2;
            2: return 4;
            default: return 8;
        endcase
    endfunction

    // Mostly well-formed register traffic and line events on a few busy lines
    function automatic item_t random_item();
        int unsigned r;
        int unsigned sz;
        int unsigned line;
        r = $urandom_range(99);
        if (r < 38) begin
            line = ($urandom_range(99) < 70) ? $urandom_range(7) : $urandom_range(31);
            return ln(line, 1'($urandom));
        end
        if (r < 66) begin
            sz = ($urandom_range(99) < 85) ? legal_size() : $urandom_range(1, 8);
            case ($urandom_range(9))
                0, 1, 2: return rd($urandom_range(31), sz);
                3: return rd(OFS_PENDING, sz);
                4: return rd(OFS_ENABLE, sz);
                5: return rd(OFS_EDGE, sz);
                6, 7: return rd(OFS_CORE_BASE + 8 * $urandom_range(3), sz);
                default: return rd($urandom_range(255), sz);
            endcase
        end
        r = $urandom_range(99);
        if (r < 45) return wr($urandom_range(31), legal_size(), {$urandom, $urandom});
        if (r < 65)
            return wr(OFS_EN_SET, ($urandom_range(1)) ? 4 : 8,
                      {$urandom & $urandom & $urandom, $urandom | $urandom});
        if (r < 77) return wr(OFS_EN_CLR, 4, {$urandom, $urandom & $urandom & $urandom});
        if (r < 85) return wr(OFS_EDGE, 4, {$urandom, $urandom});
        return wr($urandom_range(255), $urandom_range(1, 8), {$urandom, $urandom});
    endfunction

    // ------------------------------------------------------------------
    // Stream driving
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(input item_t it);
        int      gap;
        result_t r;
        gap = steady_flow ? 0 : pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = it.action;
        s_axis_tdata  = {6'b0, it.irq_level, it.irq_number, it.write_data,
                         it.access_bytes, it.address};
        do @(posedge aclk); while (!s_axis_tready);
        if (route_item(it, r)) read_pin_q.push_back(r);
    endtask

    // Stop sending and let every outstanding result drain
    task automatic wait_for_quiet();
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (read_pin_q.size() != 0) @(posedge aclk);
        repeat (IDLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_online(input int unsigned count);
        wait_for_quiet();
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = CFG_W'(count);
        do @(posedge aclk); while (!cfg_ready);
        online_q = count;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Result side back-pressure
    initial begin
        forever begin
            @(negedge aclk);
            if (steady_flow) begin
                m_axis_tready = 1'b1;
                rx_hold = 0;
            end else if (rx_hold > 0) begin
                m_axis_tready = 1'b0;
                rx_hold--;
            end else begin
                m_axis_tready = 1'b1;
                if ($urandom_range(99) < 25)
                    rx_hold = ($urandom_range(99) < 88) ? $urandom_range(1, 3)
                                                        : $urandom_range(10, 40);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (read_pin_q.size() == 0) begin
                $error("result item with nothing expected");
                mismatch_count++;
            end else begin
                head_r = read_pin_q.pop_front();
                check_field("result_kind", head_r.result_kind, m_axis_tuser[0]);
                check_field("read_data", head_r.read_data, m_axis_tdata[63:0]);
                check_field("core_index", head_r.core_index, m_axis_tdata[65:64]);
                check_field("core_pin", head_r.core_pin, m_axis_tdata[68:66]);
                check_field("pin_level", head_r.pin_level, m_axis_tdata[69]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset contents, read past the window end, bad read size
    task automatic test_reset_state();
        send_item(rd(8'h00, 8));
        send_item(rd(8'hfc, 8));
        send_item(rd(OFS_PENDING, 3));
        send_item(rd(OFS_CORE_BASE, 8));
    endtask

    // Route bytes, enable set/clear ports, edge word, ignored writes
    task automatic test_register_window();
        send_item(wr(8'h00, 8, 64'hff3cf00f_88442211));
        send_item(wr(8'h1e, 4, 64'h0000_0000_aaaa_1802));   // runs off the route block
        send_item(wr(OFS_EN_SET, 8, 64'h0000_0080_ffff_ffff));
        send_item(wr(OFS_EDGE, 4, 64'h0000_0000_0000_0001));
        send_item(wr(OFS_ENABLE, 4, 64'h0000_0000_dead_beef));
        send_item(wr(8'h10, 3, 64'h1234_5678_9abc_def0));
        send_item(rd(8'h00, 8));
        send_item(rd(8'h1c, 8));
        send_item(rd(OFS_PENDING, 8));
        send_item(rd(OFS_EDGE, 2));
    endtask

    // Raise, fall with and without other lines pending, dropped events
    task automatic test_line_routing();
        send_item(ln(0, 1'b1));
        send_item(ln(1, 1'b1));    // core 1 not online: lands on core 0
        send_item(ln(4, 1'b1));    // pin nibble zero
        send_item(ln(7, 1'b1));    // disabled line
        send_item(ln(0, 1'b0));    // core 0 still busy: no pin change
        send_item(ln(0, 1'b1));    // asserts again
        send_item(rd(OFS_CORE_BASE, 8));
        send_item(wr(OFS_EN_CLR, 4, 64'h1));   // edge line loses pending
        send_item(rd(OFS_PENDING, 8));
        send_item(ln(1, 1'b0));
        send_item(wr(OFS_EN_SET, 4, 64'h1));
        send_item(ln(0, 1'b0));    // core 0 now empty: pin drops
        send_item(ln(5, 1'b1));    // core nibble zero
    endtask

    task automatic run_traffic(input int count, input int steady_count);
        for (int i = 0; i < count; i++) begin
            steady_flow = (i < steady_count);
            if (i == count / 2) wait_for_quiet();
            send_item(random_item());
        end
        steady_flow = 1'b0;
    endtask

    // Random traffic under each online core count, extremes included
    task automatic test_online_counts();
        set_online(4);
        run_traffic(450, 120);
        set_online(2);
        run_traffic(350, 0);
        set_online(3);
        run_traffic(350, 60);
        set_online(1);
        run_traffic(400, 0);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        clear_router();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_state();
        test_register_window();
        test_line_routing();
        test_online_counts();

        wait_for_quiet();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/irr_pkg.sv
rtl/irr_regs.sv
rtl/interrupt_router_registers_core.sv
tb/tb.sv
